### sv/dog_extremum_detector_assert.svh
// ----------------------------------------------------------------------------
// dog_extremum_detector_assert.svh
// assertion macros for the checker file of the extremum detector
// ----------------------------------------------------------------------------
`ifndef DOG_EXTREMUM_DETECTOR_ASSERT_SVH
`define DOG_EXTREMUM_DETECTOR_ASSERT_SVH

// concurrent check, quiet while reset is held
`define DOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define DOG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dog_pkg.sv
// ----------------------------------------------------------------------------
// dog_pkg
// shared types and constants of the dog extremum detector
// ----------------------------------------------------------------------------
package dog_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // register widths and reset values
  localparam int THR_W   = 15;
  localparam int CFG_W_W = 12;
  localparam int CFG_H_W = 13;
  localparam logic [THR_W-1:0]   THR_RST    = 15'd983;
  localparam logic [CFG_W_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = 13'd480;

  // apb port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_t;

  // per-lane compare result against the window centre
  typedef struct packed {
    logic gt_all;   // centre above every neighbor of the lane
    logic lt_all;   // centre below every neighbor of the lane
  } lane_flags_t;

  // per-item control bits entering the merge stage
  typedef struct packed {
    logic center_valid;
    logic contrast_ok;
    logic frame_last;
  } item_meta_t;

  // result flags, center_valid in the lowest bit
  typedef struct packed {
    logic is_maximum;
    logic is_candidate;
    logic center_valid;
  } out_flags_t;

endpackage

### sv/dog_lane.sv
// ----------------------------------------------------------------------------
// dog_lane
// one scale layer: two-row line store, 3x3 window and neighbor compare
// ----------------------------------------------------------------------------
module dog_lane #(
  parameter int MAX_WIDTH   = dog_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = dog_pkg::DEF_SAMPLE_BITS,
  parameter bit IS_CENTER   = 1'b0,
  localparam int ADDR_W     = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          clr_en,
  input  logic [ADDR_W-1:0]             clr_addr,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          shift_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] center_in,
  input  logic                          flag_en,
  output logic signed [SAMPLE_BITS-1:0] center_out,
  output dog_pkg::lane_flags_t          flags_r
);
  import dog_pkg::*;

  localparam int SB = SAMPLE_BITS;

  // word = {row r-2, row r-1}
  logic [2*SB-1:0]        line_mem [MAX_WIDTH];
  logic [2*SB-1:0]        rd_r;
  logic signed [SB-1:0]   fresh_r;
  logic signed [SB-1:0]   up1;
  logic signed [SB-1:0]   up2;
  logic signed [SB-1:0]   win_r [3][3];
  lane_flags_t            flags_nxt;

  assign up1 = rd_r[SB-1:0];
  assign up2 = rd_r[2*SB-1:SB];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r    <= line_mem[rd_addr];
      fresh_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      line_mem[clr_addr] <= '0;
    end else if (shift_en) begin
      line_mem[wr_addr] <= {up1, fresh_r};
    end
  end

  // window rows: 0 = r-2, 1 = r-1, 2 = r; columns shift left
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= up1;
      win_r[2][2] <= fresh_r;
    end
  end

  assign center_out = win_r[1][1];

  always_comb begin
    flags_nxt.gt_all = 1'b1;
    flags_nxt.lt_all = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (!(IS_CENTER && r == 1 && k == 1)) begin
          if (!(center_in > win_r[r][k])) flags_nxt.gt_all = 1'b0;
          if (!(center_in < win_r[r][k])) flags_nxt.lt_all = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flag_en) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

### sv/dog_merge.sv
// ----------------------------------------------------------------------------
// dog_merge
// combines the lane compare flags into the registered result item
// ----------------------------------------------------------------------------
module dog_merge #(
  parameter int COL_W = 11,
  parameter int ROW_W = 12
) (
  input  logic                 clk,
  input  logic                 load,
  input  dog_pkg::lane_flags_t lane_flags [3],
  input  dog_pkg::item_meta_t  meta,
  input  logic [COL_W-1:0]     x,
  input  logic [ROW_W-1:0]     y,
  output dog_pkg::out_flags_t  flags_r,
  output logic [COL_W-1:0]     x_r,
  output logic [ROW_W-1:0]     y_r,
  output logic                 last_r
);
  import dog_pkg::*;

  logic       is_max;
  logic       is_min;
  out_flags_t flags_nxt;

  assign is_max = lane_flags[0].gt_all & lane_flags[1].gt_all & lane_flags[2].gt_all;
  assign is_min = lane_flags[0].lt_all & lane_flags[1].lt_all & lane_flags[2].lt_all;

  always_comb begin
    flags_nxt.center_valid = meta.center_valid;
    flags_nxt.is_candidate = meta.center_valid & meta.contrast_ok & (is_max | is_min);
    flags_nxt.is_maximum   = flags_nxt.is_candidate & is_max;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags_nxt;
      x_r     <= meta.center_valid ? x : '0;
      y_r     <= meta.center_valid ? y : '0;
      last_r  <= meta.frame_last;
    end
  end

endmodule

### sv/dog_extremum_detector.sv
// ----------------------------------------------------------------------------
// dog_extremum_detector
// 3x3x3 scale-space extremum test on a raster stream of dog sample triples
// ----------------------------------------------------------------------------
// Each input item carries the below, current and above dog samples of one
// pixel in raster order; each item yields exactly one result item, which
// reports on the window centre one column left and one row up. The block
// takes one item per clock for as long as the result side keeps up. An item
// passes the line store read at acceptance, then the window shift, the lane
// compare register and the merge register, which offers the result. Three
// lanes, one per scale layer, each hold a two-row line store (one memory of
// MAX_WIDTH words, one read and one write per item) and a 3x3 window, and
// compare their nine samples (eight in the centre lane) against the tested
// centre; the merge stage ands the lane flags and applies the contrast
// threshold. After reset the line stores are swept to zero, one address per
// cycle over all MAX_WIDTH addresses; in_tready stays low during the sweep
// while the register port works as usual. Width and height are saturated to
// [3, MAX_WIDTH] and [3, MAX_HEIGHT]. Registers: threshold at 0x0, width at
// 0x4, height at 0x8.
// ----------------------------------------------------------------------------
module dog_extremum_detector #(
  parameter int  MAX_WIDTH   = dog_pkg::DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT  = dog_pkg::DEF_MAX_HEIGHT,
  parameter int  SAMPLE_BITS = dog_pkg::DEF_SAMPLE_BITS,
  localparam int COL_W       = $clog2(MAX_WIDTH),
  localparam int ROW_W       = $clog2(MAX_HEIGHT),
  localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((COL_W + ROW_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // below_sample, current_sample, above_sample (lowest bits first)
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // center_x, center_y (lowest bits first)
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  // center_valid, is_candidate, is_maximum (lowest bit first)
  output logic [2:0]                      out_tuser,
  // frame_last
  output logic                            out_tlast,
  // register port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dog_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [dog_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dog_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import dog_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int WV_W  = (COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W;
  localparam int HV_W  = (ROW_W + 1 > CFG_H_W) ? ROW_W + 1 : CFG_H_W;
  localparam int MAG_W = (SB + 1 > THR_W) ? SB + 1 : THR_W;
  localparam logic [WV_W-1:0]  W_MAX   = WV_W'(MAX_WIDTH);
  localparam logic [WV_W-1:0]  W_MIN   = WV_W'(3);
  localparam logic [HV_W-1:0]  H_MAX   = HV_W'(MAX_HEIGHT);
  localparam logic [HV_W-1:0]  H_MIN   = HV_W'(3);
  localparam logic [COL_W-1:0] CLR_END = COL_W'(MAX_WIDTH - 1);

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0]   cfg_thr_r;
  logic [CFG_W_W-1:0] cfg_width_r;
  logic [CFG_H_W-1:0] cfg_height_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_thr_r    <= THR_RST;
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESHOLD: cfg_thr_r    <= cfg_pwdata[THR_W-1:0];
        REG_WIDTH:     cfg_width_r  <= cfg_pwdata[CFG_W_W-1:0];
        REG_HEIGHT:    cfg_height_r <= cfg_pwdata[CFG_H_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD: cfg_prdata = CFG_DATA_W'(cfg_thr_r);
      REG_WIDTH:     cfg_prdata = CFG_DATA_W'(cfg_width_r);
      REG_HEIGHT:    cfg_prdata = CFG_DATA_W'(cfg_height_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // saturated frame size
  logic [WV_W-1:0] width_ext;
  logic [HV_W-1:0] height_ext;
  logic [WV_W-1:0] w_eff;
  logic [HV_W-1:0] h_eff;

  assign width_ext  = WV_W'(cfg_width_r);
  assign height_ext = HV_W'(cfg_height_r);
  assign w_eff = (width_ext < W_MIN) ? W_MIN : ((width_ext > W_MAX) ? W_MAX : width_ext);
  assign h_eff = (height_ext < H_MIN) ? H_MIN : ((height_ext > H_MAX) ? H_MAX : height_ext);

  // ---------------- line store clearing sweep ----------------
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_END) clr_busy_r <= 1'b0;
    end
  end

  // ---------------- pipeline control ----------------
  // stage a: line store read, stage b: window, stage c: lane flags,
  // then the output register; each stage advances into a free slot
  logic a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic en_out, en_c, en_b, en_a;
  logic acc;

  assign en_out    = !out_valid_r || out_tready;
  assign en_c      = !c_valid_r || en_out;
  assign en_b      = !b_valid_r || en_c;
  assign en_a      = !a_valid_r || en_b;
  assign in_tready = en_a && !clr_busy_r;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a)   a_valid_r   <= acc;
      if (en_b)   b_valid_r   <= a_valid_r;
      if (en_c)   c_valid_r   <= b_valid_r;
      if (en_out) out_valid_r <= c_valid_r;
    end
  end

  // ---------------- raster position ----------------
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [WV_W-1:0]  col_inc;
  logic [HV_W-1:0]  row_inc;
  logic             col_last;
  logic             row_last;

  assign col_inc  = WV_W'(col_r) + 1'b1;
  assign row_inc  = HV_W'(row_r) + 1'b1;
  assign col_last = col_inc >= w_eff;
  assign row_last = row_inc >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // ---------------- item payload along the stages ----------------
  logic [COL_W-1:0] a_col_r;
  logic [ROW_W-1:0] a_row_r;
  logic             a_cvalid_r;
  logic             a_last_r;
  logic [COL_W-1:0] b_x_r;
  logic [ROW_W-1:0] b_y_r;
  logic             b_cvalid_r;
  logic             b_last_r;
  logic [COL_W-1:0] c_x_r;
  logic [ROW_W-1:0] c_y_r;
  item_meta_t       c_meta_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      a_col_r    <= col_r;
      a_row_r    <= row_r;
      a_cvalid_r <= (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
      a_last_r   <= col_last && row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid_r) begin
      b_x_r      <= a_col_r - 1'b1;
      b_y_r      <= a_row_r - 1'b1;
      b_cvalid_r <= a_cvalid_r;
      b_last_r   <= a_last_r;
    end
  end

  // ---------------- lanes: below, current, above ----------------
  logic signed [SB-1:0] lane_center [3];
  lane_flags_t          lane_flags  [3];
  logic                 shift_en;
  logic                 flag_en;

  assign shift_en = en_b && a_valid_r;
  assign flag_en  = en_c && b_valid_r;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    dog_lane #(
      .MAX_WIDTH  (MAX_WIDTH),
      .SAMPLE_BITS(SAMPLE_BITS),
      .IS_CENTER  (l == 1)
    ) u_lane (
      .clk       (clk),
      .clr_en    (clr_busy_r),
      .clr_addr  (clr_cnt_r),
      .rd_en     (acc),
      .rd_addr   (col_r),
      .in_sample (in_tdata[l*SB +: SB]),
      .shift_en  (shift_en),
      .wr_addr   (a_col_r),
      .center_in (lane_center[1]),
      .flag_en   (flag_en),
      .center_out(lane_center[l]),
      .flags_r   (lane_flags[l])
    );
  end

  // contrast test on the centre of the tested layer, stage b
  logic signed [SB:0] center_ext;
  logic signed [SB:0] mag_s;
  logic [MAG_W-1:0]   mag;
  logic               contrast_ok;

  assign center_ext  = {lane_center[1][SB-1], lane_center[1]};
  assign mag_s       = center_ext[SB] ? -center_ext : center_ext;
  assign mag         = MAG_W'(mag_s);
  assign contrast_ok = mag >= MAG_W'(cfg_thr_r);

  always_ff @(posedge clk) begin
    if (flag_en) begin
      c_x_r                 <= b_x_r;
      c_y_r                 <= b_y_r;
      c_meta_r.center_valid <= b_cvalid_r;
      c_meta_r.contrast_ok  <= contrast_ok;
      c_meta_r.frame_last   <= b_last_r;
    end
  end

  // ---------------- merge and output register ----------------
  out_flags_t       out_flags;
  logic [COL_W-1:0] out_x;
  logic [ROW_W-1:0] out_y;

  dog_merge #(
    .COL_W(COL_W),
    .ROW_W(ROW_W)
  ) u_merge (
    .clk       (clk),
    .load      (en_out && c_valid_r),
    .lane_flags(lane_flags),
    .meta      (c_meta_r),
    .x         (c_x_r),
    .y         (c_y_r),
    .flags_r   (out_flags),
    .x_r       (out_x),
    .y_r       (out_y),
    .last_r    (out_tlast)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_y, out_x});
  assign out_tuser  = out_flags;

endmodule

### sv/dog_chk.sv
// ----------------------------------------------------------------------------
// dog_chk
// port-level checks of the dog extremum detector, bound to the top level
// ----------------------------------------------------------------------------
`include "dog_extremum_detector_assert.svh"

module dog_chk #(
  parameter int OUT_TDATA_W = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]             out_tuser,
  input logic                   out_tlast
);

  // stalled result keeps its place and its payload
  `DOG_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped while stalled")
  `DOG_ASSERT(a_out_stable, (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)), "stalled result changed")

  // border centres carry no coordinates and no flags
  `DOG_ASSERT(a_border_clean, (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0 && out_tuser[2:1] == 2'b00), "border result not cleared")

  // a maximum is always a candidate
  `DOG_ASSERT(a_max_is_cand, (out_tvalid && out_tuser[2]) |-> out_tuser[1], "maximum without candidate")

  // reset empties the pipeline and starts the store sweep
  `DOG_ASSERT_ANY(a_reset_quiet, !rst_n |=> (!in_tready && !out_tvalid), "activity right after reset")

endmodule

bind dog_extremum_detector dog_chk #(
  .OUT_TDATA_W(OUT_TDATA_W)
) u_dog_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
